### rtl/exts_pkg.sv
// shared constants, types and the microcode table for the exp taylor series block
// no dependencies; used by exts_datapath, exp_taylor_series and exts_checker
`default_nettype none

package exts_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_TERMS = 32;
  localparam int X_W       = 22;
  localparam int XMAG_W    = 21;
  localparam int VAL_W     = 48;
  localparam int N_W       = 6;
  localparam int HALF_W    = 24;
  localparam int MULP_W    = HALF_W + XMAG_W;
  localparam int PROD_W    = VAL_W + XMAG_W;
  localparam int DIV_BITS  = 8;
  localparam int DQ_W      = 56;
  localparam int DIV_LAST  = DQ_W / DIV_BITS - 1;
  localparam int CNT_W     = 3;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [N_W-1:0]   CFG_RESET = N_W'(10);
  localparam logic [N_W-1:0]   LAST_MAX  = N_W'(MAX_TERMS);
  localparam logic [X_W-1:0]   X_LIM     = X_W'(64'd16 << FRAC_BITS);
  localparam logic [VAL_W-1:0] VAL_ONE   = VAL_W'(64'd1 << FRAC_BITS);
  localparam logic [VAL_W-1:0] POS_MAX   = VAL_W'((64'd1 << (VAL_W - 1)) - 64'd1);
  localparam logic [VAL_W-1:0] NEG_MIN   = VAL_W'(64'd1 << (VAL_W - 1));
  localparam logic [DQ_W-1:0]  Q_MAG_LIM = DQ_W'(64'd1 << (VAL_W - 1));
  localparam logic [DQ_W-1:0]  Q_POS_MAX = DQ_W'((64'd1 << (VAL_W - 1)) - 64'd1);

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_CHECK,
    STEP_MUL_LO,
    STEP_MUL_HI,
    STEP_DIV_INIT,
    STEP_DIV,
    STEP_TERM,
    STEP_DONE
  } step_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_NONE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_DIV_INIT,
    OP_DIV,
    OP_TERM,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    COND_NO_INPUT,
    COND_N_GT_LAST,
    COND_DIV_MORE,
    COND_ALWAYS,
    COND_OUT_BUSY,
    COND_NEVER
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic en;
  } ctrl_t;

  typedef struct packed {
    logic n_gt_last;
    logic div_more;
  } status_t;

  // microcode: a taken condition jumps to target, otherwise the next step
  function automatic uword_t urom(step_t s);
    uword_t w;
    unique case (s)
      STEP_IDLE:     w = '{op: OP_LOAD,     cond: COND_NO_INPUT,  target: STEP_IDLE};
      STEP_CHECK:    w = '{op: OP_NONE,     cond: COND_N_GT_LAST, target: STEP_DONE};
      STEP_MUL_LO:   w = '{op: OP_MUL_LO,   cond: COND_NEVER,     target: STEP_IDLE};
      STEP_MUL_HI:   w = '{op: OP_MUL_HI,   cond: COND_NEVER,     target: STEP_IDLE};
      STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEVER,     target: STEP_IDLE};
      STEP_DIV:      w = '{op: OP_DIV,      cond: COND_DIV_MORE,  target: STEP_DIV};
      STEP_TERM:     w = '{op: OP_TERM,     cond: COND_ALWAYS,    target: STEP_CHECK};
      STEP_DONE:     w = '{op: OP_OUT,      cond: COND_OUT_BUSY,  target: STEP_DONE};
      default:       w = '{op: OP_NONE,     cond: COND_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/exts_datapath.sv
// arithmetic datapath: argument clamp, term multiply, divide by term index, saturating sum
// depends on exts_pkg; driven one op per cycle, gated by ctrl.en, by the sequencer in exp_taylor_series
`default_nettype none

module exts_datapath import exts_pkg::*; (
  input  wire logic                    clk,
  input  wire ctrl_t                   ctrl,
  input  wire logic signed [X_W-1:0]   x_in,
  input  wire logic [N_W-1:0]          cfg_last,
  output status_t                      stat,
  output logic [VAL_W-1:0]             sum,
  output logic                         ovf
);

  logic                x_neg;
  logic [XMAG_W-1:0]   x_mag;
  logic [N_W-1:0]      last;
  logic [N_W-1:0]      n;
  logic [VAL_W-1:0]    term;
  logic [PROD_W-1:0]   prod;
  logic [DQ_W-1:0]     dq;
  logic [N_W-1:0]      rem;
  logic [CNT_W-1:0]    cnt;

  logic signed [X_W-1:0] xc;
  logic [X_W-1:0]        xc_abs;
  logic [VAL_W-1:0]      tmag;
  logic [HALF_W-1:0]     mul_a;
  logic [MULP_W-1:0]     mul;
  logic [DQ_W-1:0]       dq_next;
  logic [N_W-1:0]        rem_next;
  logic                  q_neg;
  logic                  term_sat;
  logic [VAL_W-1:0]      term_next;
  logic [VAL_W:0]        sum_w;
  logic                  sum_sat;
  logic [VAL_W-1:0]      sum_next;

  // clamp to +-16.0
  always_comb begin
    if (x_in > $signed(X_LIM)) begin
      xc = $signed(X_LIM);
    end else if (x_in < -$signed(X_LIM)) begin
      xc = -$signed(X_LIM);
    end else begin
      xc = x_in;
    end
    xc_abs = xc[X_W-1] ? X_W'(-xc) : X_W'(xc);
  end

  assign tmag  = term[VAL_W-1] ? (~term + VAL_W'(1)) : term;
  assign mul_a = (ctrl.op == OP_MUL_HI) ? tmag[VAL_W-1:HALF_W] : tmag[HALF_W-1:0];
  assign mul   = MULP_W'(mul_a) * MULP_W'(x_mag);

  // eight quotient bits a cycle, restoring
  always_comb begin
    logic [N_W-1:0] r;
    logic [DQ_W-1:0] d;
    logic [N_W:0] rs;
    logic ge;
    r = rem;
    d = dq;
    for (int i = 0; i < DIV_BITS; i++) begin
      rs = {r, d[DQ_W-1]};
      ge = rs >= {1'b0, n};
      d  = {d[DQ_W-2:0], ge};
      if (ge) begin
        rs = rs - {1'b0, n};
      end
      r = rs[N_W-1:0];
    end
    dq_next  = d;
    rem_next = r;
  end

  // signed, saturated term and partial sum
  always_comb begin
    q_neg = (term[VAL_W-1] != x_neg) && (dq != '0);
    if (q_neg) begin
      term_sat  = dq > Q_MAG_LIM;
      term_next = term_sat ? NEG_MIN : (~dq[VAL_W-1:0] + VAL_W'(1));
    end else begin
      term_sat  = dq > Q_POS_MAX;
      term_next = term_sat ? POS_MAX : dq[VAL_W-1:0];
    end
    sum_w   = {sum[VAL_W-1], sum} + {term_next[VAL_W-1], term_next};
    sum_sat = sum_w[VAL_W] != sum_w[VAL_W-1];
    if (sum_sat) begin
      sum_next = sum_w[VAL_W] ? NEG_MIN : POS_MAX;
    end else begin
      sum_next = sum_w[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      case (ctrl.op)
        OP_LOAD: begin
          x_neg <= xc[X_W-1];
          x_mag <= xc_abs[XMAG_W-1:0];
          last  <= (cfg_last > LAST_MAX) ? LAST_MAX : cfg_last;
          n     <= N_W'(1);
          term  <= VAL_ONE;
          sum   <= VAL_ONE;
          ovf   <= 1'b0;
        end
        OP_MUL_LO: begin
          prod <= PROD_W'(mul);
        end
        OP_MUL_HI: begin
          prod <= prod + {mul, {HALF_W{1'b0}}};
        end
        OP_DIV_INIT: begin
          dq  <= DQ_W'(prod[PROD_W-1:FRAC_BITS]);
          rem <= '0;
          cnt <= '0;
        end
        OP_DIV: begin
          dq  <= dq_next;
          rem <= rem_next;
          cnt <= cnt + CNT_W'(1);
        end
        OP_TERM: begin
          term <= term_next;
          sum  <= sum_next;
          ovf  <= ovf | term_sat | sum_sat;
          n    <= n + N_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.n_gt_last = n > last;
  assign stat.div_more  = cnt != CNT_W'(DIV_LAST);

endmodule

`default_nettype wire

### rtl/exp_taylor_series.sv
// exp taylor series top level: apb register, stream ports, microcode sequencer, output register
// depends on exts_pkg and exts_datapath
`default_nettype none

// Computes e^x as the Taylor series summed over terms 0 to last_term_index (capped at 32),
// x signed Q6.16 clamped to -16..16, result signed Q32.16 saturated, with an overflow
// flag in m_tuser. Each term is term*x/n truncated toward zero. One item is processed at
// a time. Each term uses a shared 24x21 multiplier on the low and then the high half of
// the term, and a divider that retires eight quotient bits a cycle; a result that waits
// in the output register does not block the next request from being accepted.
module exp_taylor_series import exts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [23:0]       s_tdata,   // x[21:0], zero pad
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [47:0]            m_tdata,   // result[47:0]
  output logic [0:0]             m_tuser    // overflow
);

  logic [N_W-1:0]   cfg_last;
  step_t            pc;
  step_t            pc_next;
  uword_t           uw;
  ctrl_t            ctrl;
  status_t          stat;
  logic             jump;
  logic             accept;
  logic             out_busy;
  logic [VAL_W-1:0] sum;
  logic             ovf;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_last <= CFG_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      cfg_last <= pwdata[N_W-1:0];
    end
  end

  assign prdata = paddr[2] ? '0 : DATA_W'(cfg_last);

  assign s_tready = (pc == STEP_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;
  assign uw       = urom(pc);

  always_comb begin
    unique case (uw.cond)
      COND_NO_INPUT:  jump = !s_tvalid;
      COND_N_GT_LAST: jump = stat.n_gt_last;
      COND_DIV_MORE:  jump = stat.div_more;
      COND_ALWAYS:    jump = 1'b1;
      COND_OUT_BUSY:  jump = out_busy;
      default:        jump = 1'b0;
    endcase
    pc_next = jump ? uw.target : step_t'(3'(pc + 3'd1));
    ctrl.op = uw.op;
    case (uw.op)
      OP_LOAD: ctrl.en = accept;
      OP_OUT:  ctrl.en = !out_busy;
      default: ctrl.en = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  exts_datapath u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .x_in     (s_tdata[X_W-1:0]),
    .cfg_last (cfg_last),
    .stat     (stat),
    .sum      (sum),
    .ovf      (ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.op == OP_OUT && ctrl.en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_OUT && ctrl.en) begin
      m_tdata <= sum;
      m_tuser <= ovf;
    end
  end

endmodule

`default_nettype wire

### rtl/exts_checker.sv
// port-level checks for exp_taylor_series, attached by the bind at the end
// depends on exts_pkg for the port widths
`default_nettype none

module exts_checker import exts_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [ADDR_W-1:0] paddr,
  input wire logic [DATA_W-1:0] pwdata,
  input wire logic [DATA_W-1:0] prdata,
  input wire logic              pready,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [47:0]       m_tdata,
  input wire logic [0:0]        m_tuser
);

  // no result pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // an accepted request makes the block busy, with s_tready held low after the accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("request accepted while busy");

  // register read back after a write to it
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && !paddr[2] ##1 !paddr[2]
    |-> prdata[N_W-1:0] == $past(pwdata[N_W-1:0]))
    else $error("register read back mismatch");

endmodule

bind exp_taylor_series exts_checker u_exts_checker (.*);

`default_nettype wire

### test/tb_exp_taylor_series.sv
// testbench for exp_taylor_series: directed table then random requests over several
// last_term_index settings, every result checked against its table value or a fixed-point series predictor
// depends on exts_pkg and the exp_taylor_series rtl
module tb_exp_taylor_series;
  import exts_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_IDX_ADDR = '0;
  localparam int                 CYCLE_LIMIT   = 3_000_000;
  localparam int                 DRAIN_CYCLES  = 400;
  localparam int                 PHASES        = 6;
  localparam int                 PHASE_ITEMS   = 100;
  localparam longint             VAL_HI        = (64'sd1 <<< (VAL_W - 1)) - 1;
  localparam longint             VAL_LO        = -(64'sd1 <<< (VAL_W - 1));

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             ovf;
  } series_t;

  typedef struct packed {
    logic [N_W-1:0]   cfg;
    logic [X_W-1:0]   x;
    bit               known;
    logic [VAL_W-1:0] value;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              s_tvalid;
  logic              s_tready;
  logic [23:0]       s_tdata;   // x[21:0], zero pad
  logic              m_tvalid;
  logic              m_tready;
  logic [47:0]       m_tdata;   // result[47:0]
  logic [0:0]        m_tuser;   // overflow

  series_t        pending_sums[$];
  logic [N_W-1:0] last_cfg;
  int             err_cnt;
  int             cycles;
  int             burst_left;
  int             gap_len;
  bit             idle_on;

  dir_row_t dir_tab [22] = '{
    '{6'd10, 22'h000000, 1'b1, 48'h0000_0001_0000},
    '{6'd10, 22'h010000, 1'b0, 48'h0},
    '{6'd10, 22'h3F0000, 1'b0, 48'h0},
    '{6'd10, 22'h000001, 1'b0, 48'h0},
    '{6'd10, 22'h3FFFFF, 1'b0, 48'h0},
    '{6'd10, 22'h100000, 1'b0, 48'h0},
    '{6'd10, 22'h300000, 1'b0, 48'h0},
    '{6'd10, 22'h1FFFFF, 1'b0, 48'h0},
    '{6'd10, 22'h200000, 1'b0, 48'h0},
    '{6'd10, 22'h100001, 1'b0, 48'h0},
    '{6'd10, 22'h2FFFFF, 1'b0, 48'h0},
    '{6'd0,  22'h1FFFFF, 1'b1, 48'h0000_0001_0000},
    '{6'd0,  22'h200000, 1'b1, 48'h0000_0001_0000},
    '{6'd1,  22'h010000, 1'b1, 48'h0000_0002_0000},
    '{6'd1,  22'h200000, 1'b1, 48'hFFFF_FFF1_0000},
    '{6'd32, 22'h100000, 1'b0, 48'h0},
    '{6'd32, 22'h300000, 1'b0, 48'h0},
    '{6'd32, 22'h1FFFFF, 1'b0, 48'h0},
    '{6'd32, 22'h008000, 1'b0, 48'h0},
    '{6'd63, 22'h100000, 1'b0, 48'h0},
    '{6'd63, 22'h300000, 1'b0, 48'h0},
    '{6'd63, 22'h000000, 1'b1, 48'h0000_0001_0000}
  };

  exp_taylor_series u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // series sum with each term built as prev*x/n, truncated, saturating at 48 bits
  function automatic series_t exp_series(input logic [X_W-1:0] xraw,
                                         input logic [N_W-1:0] last_idx);
    longint       x;
    longint       lim;
    longint       term;
    longint       acc;
    logic [63:0]  xmag;
    logic [63:0]  tmag;
    logic [127:0] quo;
    int           last;
    int           n;
    bit           xneg;
    bit           tneg;
    bit           ovf;
    series_t      r;
    x    = longint'($signed(xraw));
    lim  = 64'sd16 <<< FRAC_BITS;
    if (x > lim) x = lim;
    if (x < -lim) x = -lim;
    last = (int'(last_idx) > MAX_TERMS) ? MAX_TERMS : int'(last_idx);
    term = 64'sd1 <<< FRAC_BITS;
    acc  = term;
    ovf  = 1'b0;
    xneg = x < 0;
    xmag = xneg ? -x : x;
    for (n = 1; n <= last; n++) begin
      tneg = term < 0;
      tmag = tneg ? -term : term;
      quo  = (128'(tmag) * 128'(xmag)) / (128'(n) << FRAC_BITS);
      if (tneg != xneg && quo != 0) begin
        if (quo > 128'(-VAL_LO)) begin
          term = VAL_LO;
          ovf  = 1'b1;
        end else begin
          term = -longint'(quo[63:0]);
        end
      end else begin
        if (quo > 128'(VAL_HI)) begin
          term = VAL_HI;
          ovf  = 1'b1;
        end else begin
          term = longint'(quo[63:0]);
        end
      end
      acc += term;
      if (acc > VAL_HI) begin
        acc = VAL_HI;
        ovf = 1'b1;
      end else if (acc < VAL_LO) begin
        acc = VAL_LO;
        ovf = 1'b1;
      end
    end
    r.value = acc[VAL_W-1:0];
    r.ovf   = ovf;
    return r;
  endfunction

  task automatic send_x(input logic [X_W-1:0] xv, input bit known,
                        input logic [VAL_W-1:0] kval);
    series_t e;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_len    = idle_on ? $urandom_range(0, 20) : 0;
    end
    burst_left--;
    @(negedge clk);
    if (gap_len > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_len) @(negedge clk);
      gap_len = 0;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, xv};
    do @(posedge clk); while (!s_tready);
    if (known) begin
      e.value = kval;
      e.ovf   = 1'b0;
    end else begin
      e = exp_series(xv, last_cfg);
    end
    pending_sums.push_back(e);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_last_idx(input logic [N_W-1:0] val);
    logic [DATA_W-1:0] d;
    d = {$urandom} & ~DATA_W'(6'h3F) | DATA_W'(val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LAST_IDX_ADDR;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    last_cfg = d[N_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [X_W-1:0] rand_x();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      v = int'($urandom_range(0, 32'h200000)) - 32'sh100000;
    end else if (sel <= 7) begin
      v = int'($urandom_range(0, 32'h80000)) - 32'sh40000;
    end else begin
      v = int'($urandom);
    end
    return v[X_W-1:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver holds each ready level for a random stretch, mostly ready
  initial begin
    int hold;
    hold     = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        hold = $urandom_range(1, 40);
        m_tready <= ($urandom_range(0, 3) != 0);
      end else begin
        hold--;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    series_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result %h overflow %b", m_tdata, m_tuser);
        err_cnt++;
      end else begin
        e = pending_sums.pop_front();
        if (m_tdata !== e.value) begin
          $error("result: expected %h, got %h", e.value, m_tdata);
          err_cnt++;
        end
        if (m_tuser[0] !== e.ovf) begin
          $error("overflow: expected %b, got %b", e.ovf, m_tuser[0]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int p;
    int i;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    last_cfg   = CFG_RESET;
    err_cnt    = 0;
    cycles     = 0;
    burst_left = 0;
    gap_len    = 0;
    idle_on    = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < 22; i++) begin
      if (dir_tab[i].cfg != last_cfg) begin
        stop_sending();
        wait_drain();
        write_last_idx(dir_tab[i].cfg);
      end
      send_x(dir_tab[i].x, dir_tab[i].known, dir_tab[i].value);
    end

    for (p = 0; p < PHASES; p++) begin
      stop_sending();
      wait_drain();
      write_last_idx(p == 0 ? 6'd32 : p == PHASES - 1 ? 6'd63 : N_W'($urandom_range(0, 63)));
      idle_on = (p != 3);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) begin
          stop_sending();
          wait_drain();
        end
        send_x(rand_x(), 1'b0, '0);
      end
    end

    stop_sending();
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_sums.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/exts_pkg.sv
rtl/exts_datapath.sv
rtl/exp_taylor_series.sv
rtl/exts_checker.sv
test/tb_exp_taylor_series.sv
